// ===== rtl/core/circuit_breaker_fsm_macros.svh =====
// ----------------------------------------------------------------------------
// Circuit breaker assertion macros
// Shared concurrent assertion forms for the circuit breaker design.
// ----------------------------------------------------------------------------
`ifndef CIRCUIT_BREAKER_FSM_MACROS_SVH
`define CIRCUIT_BREAKER_FSM_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CBF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CBF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/cbf_pkg.sv =====
// ----------------------------------------------------------------------------
// Circuit breaker package
// Types and constants shared by the circuit breaker step logic and top level.
// ----------------------------------------------------------------------------
package cbf_pkg;

   // Breaker mode, as reported on the result channel.
   typedef enum logic [1:0] {
      MODE_CLOSED = 2'd0,
      MODE_OPEN   = 2'd1,
      MODE_HALF   = 2'd2
   } mode_type;

   // Event opcode carried with every request.
   typedef enum logic [1:0] {
      OP_REQUEST = 2'd0,
      OP_SUCCESS = 2'd1,
      OP_FAILURE = 2'd2,
      OP_RESET   = 2'd3
   } opcode_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_TRIP_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_OPEN_TIMEOUT   = 2'd1;
   localparam logic [1:0] CSR_PROBE_LIMIT    = 2'd2;

   // Configuration register reset values.
   localparam logic [15:0] TRIP_THRESHOLD_RESET = 16'd5;
   localparam logic [31:0] OPEN_TIMEOUT_RESET   = 32'd30000;
   localparam logic [7:0]  PROBE_LIMIT_RESET    = 8'd3;

   // Configuration register set.
   typedef struct packed {
      logic [15:0] trip_threshold;
      logic [31:0] open_timeout;
      logic [7:0]  probe_limit;
   } brk_cfg_type;

   // Mode and run counters of the breaker.
   typedef struct packed {
      mode_type    mode;
      logic [15:0] failure_run;
      logic [7:0]  probe_requests;
      logic [7:0]  probe_successes;
   } brk_ctrl_type;

endpackage

// ===== rtl/core/cbf_step.sv =====
// ----------------------------------------------------------------------------
// Circuit breaker step logic
// Combinational next-state logic: applies one event to the breaker state.
// ----------------------------------------------------------------------------
module cbf_step
   import cbf_pkg::*;
#(
   parameter int TIME_WIDTH  = 32,
   parameter int TOTAL_WIDTH = 32
) (
   input  brk_cfg_type            cfg,
   input  opcode_type             opcode,
   input  logic [31:0]            now_time,
   input  brk_ctrl_type           ctrl_cur,
   input  logic [TIME_WIDTH-1:0]  change_time_cur,
   input  logic [TOTAL_WIDTH-1:0] success_cur,
   input  logic [TOTAL_WIDTH-1:0] failure_cur,
   input  logic [TOTAL_WIDTH-1:0] reject_cur,
   output brk_ctrl_type           ctrl_nxt,
   output logic [TIME_WIDTH-1:0]  change_time_nxt,
   output logic [TOTAL_WIDTH-1:0] success_nxt,
   output logic [TOTAL_WIDTH-1:0] failure_nxt,
   output logic [TOTAL_WIDTH-1:0] reject_nxt,
   output logic                   admitted
);

   // Width used to compare elapsed time with the 32-bit timeout.
   localparam int CMP_WIDTH = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

   logic [TIME_WIDTH-1:0] now_t;
   logic [TIME_WIDTH-1:0] elapsed;
   logic                  timed_out;
   logic [15:0]           failure_run_inc;
   logic [7:0]            probe_successes_inc;

   // Elapsed time wraps at the time width; the run counters saturate.
   assign now_t     = TIME_WIDTH'(now_time);
   assign elapsed   = now_t - change_time_cur;
   assign timed_out = CMP_WIDTH'(elapsed) >= CMP_WIDTH'(cfg.open_timeout);

   assign failure_run_inc = (ctrl_cur.failure_run == '1) ? ctrl_cur.failure_run
                                                          : ctrl_cur.failure_run + 16'd1;
   assign probe_successes_inc = (ctrl_cur.probe_successes == '1) ?
                                ctrl_cur.probe_successes :
                                ctrl_cur.probe_successes + 8'd1;

   // Apply the event.
   always_comb begin
      ctrl_nxt        = ctrl_cur;
      change_time_nxt = change_time_cur;
      success_nxt     = success_cur;
      failure_nxt     = failure_cur;
      reject_nxt      = reject_cur;
      admitted        = 1'b0;

      unique case (opcode)
         OP_REQUEST: begin
            unique case (ctrl_cur.mode)
               MODE_CLOSED: begin
                  admitted = 1'b1;
               end
               MODE_OPEN: begin
                  if (timed_out) begin
                     // The first request after the timeout probes.
                     ctrl_nxt.mode            = MODE_HALF;
                     ctrl_nxt.probe_requests  = 8'd0;
                     ctrl_nxt.probe_successes = 8'd0;
                     change_time_nxt          = now_t;
                     admitted                 = 1'b1;
                  end else begin
                     reject_nxt = reject_cur + TOTAL_WIDTH'(1);
                  end
               end
               MODE_HALF: begin
                  if (ctrl_cur.probe_requests < cfg.probe_limit) begin
                     ctrl_nxt.probe_requests = ctrl_cur.probe_requests + 8'd1;
                     admitted                = 1'b1;
                  end else begin
                     reject_nxt = reject_cur + TOTAL_WIDTH'(1);
                  end
               end
               default: begin
               end
            endcase
         end
         OP_SUCCESS: begin
            success_nxt = success_cur + TOTAL_WIDTH'(1);
            if (ctrl_cur.mode == MODE_HALF) begin
               ctrl_nxt.probe_successes = probe_successes_inc;
               if (probe_successes_inc >= cfg.probe_limit) begin
                  ctrl_nxt.mode   = MODE_CLOSED;
                  change_time_nxt = now_t;
               end
            end
            // A success in closed mode, or one that closes, clears the run.
            if (ctrl_nxt.mode == MODE_CLOSED) begin
               ctrl_nxt.failure_run = 16'd0;
            end
         end
         OP_FAILURE: begin
            failure_nxt = failure_cur + TOTAL_WIDTH'(1);
            if (ctrl_cur.mode == MODE_CLOSED) begin
               ctrl_nxt.failure_run = failure_run_inc;
               if (failure_run_inc >= cfg.trip_threshold) begin
                  ctrl_nxt.mode   = MODE_OPEN;
                  change_time_nxt = now_t;
               end
            end else if (ctrl_cur.mode == MODE_HALF) begin
               ctrl_nxt.mode   = MODE_OPEN;
               change_time_nxt = now_t;
            end
         end
         OP_RESET: begin
            ctrl_nxt.mode            = MODE_CLOSED;
            ctrl_nxt.failure_run     = 16'd0;
            ctrl_nxt.probe_requests  = 8'd0;
            ctrl_nxt.probe_successes = 8'd0;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/core/circuit_breaker_fsm.sv =====
// ----------------------------------------------------------------------------
// Circuit breaker
// Three-mode circuit breaker (closed, open, half-open) driven by one event
// per request, reporting the mode and running totals after every event.
// ----------------------------------------------------------------------------
// The block takes one event per clock cycle unless the result channel stalls,
// and returns one result per event, in order. Each event passes through an
// input register and then through the combinational step logic into the
// breaker state, which also forms the result. Throughput is one event per
// cycle while the result is not stalled, set by the step logic (one time
// subtract and compare plus narrow counter updates). A stalled result holds
// the pipeline, with up to one further event waiting in the input register.
// Configuration writes are accepted at any cycle and apply to the next event.
// ----------------------------------------------------------------------------
`include "circuit_breaker_fsm_macros.svh"

module circuit_breaker_fsm
   import cbf_pkg::*;
#(
   parameter int TIME_WIDTH  = 32,
   parameter int TOTAL_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // [31:0] now_time
   input  logic [1:0]   req_tuser,   // [1:0] opcode
   // Result channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // [0] admitted, [2:1] mode, [34:3] success_total,
                                     // [66:35] failure_total, [98:67] reject_total,
                                     // [103:99] zero
   // Configuration write channel.
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   // Width to which the totals are extended before the 32-bit result.
   localparam int OUT_WIDTH = (TOTAL_WIDTH > 32) ? TOTAL_WIDTH : 32;

   brk_cfg_type            cfg_ff;
   logic                   in_valid_ff;
   opcode_type             in_opcode_ff;
   logic [31:0]            in_time_ff;
   logic                   advance;
   logic                   out_free;

   brk_ctrl_type           ctrl_ff;
   brk_ctrl_type           ctrl_in;
   logic [TIME_WIDTH-1:0]  change_time_ff;
   logic [TIME_WIDTH-1:0]  change_time_in;
   logic [TOTAL_WIDTH-1:0] success_ff;
   logic [TOTAL_WIDTH-1:0] success_in;
   logic [TOTAL_WIDTH-1:0] failure_ff;
   logic [TOTAL_WIDTH-1:0] failure_in;
   logic [TOTAL_WIDTH-1:0] reject_ff;
   logic [TOTAL_WIDTH-1:0] reject_in;
   logic                   admitted_in;
   logic                   admitted_ff;
   logic                   rsp_valid_ff;
   logic [OUT_WIDTH-1:0]   success_ext;
   logic [OUT_WIDTH-1:0]   failure_ext;
   logic [OUT_WIDTH-1:0]   reject_ext;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trip_threshold <= TRIP_THRESHOLD_RESET;
         cfg_ff.open_timeout   <= OPEN_TIMEOUT_RESET;
         cfg_ff.probe_limit    <= PROBE_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TRIP_THRESHOLD: cfg_ff.trip_threshold <= csr_wdata[15:0];
            CSR_OPEN_TIMEOUT:   cfg_ff.open_timeout   <= csr_wdata;
            CSR_PROBE_LIMIT:    cfg_ff.probe_limit    <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // Handshake: the input register moves on whenever the result slot is free.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_opcode_ff <= opcode_type'(req_tuser);
         in_time_ff   <= req_tdata;
      end
   end

   // Next-state logic for one event.
   cbf_step #(
      .TIME_WIDTH  (TIME_WIDTH),
      .TOTAL_WIDTH (TOTAL_WIDTH)
   ) u_step (
      .cfg             (cfg_ff),
      .opcode          (in_opcode_ff),
      .now_time        (in_time_ff),
      .ctrl_cur        (ctrl_ff),
      .change_time_cur (change_time_ff),
      .success_cur     (success_ff),
      .failure_cur     (failure_ff),
      .reject_cur      (reject_ff),
      .ctrl_nxt        (ctrl_in),
      .change_time_nxt (change_time_in),
      .success_nxt     (success_in),
      .failure_nxt     (failure_in),
      .reject_nxt      (reject_in),
      .admitted        (admitted_in)
   );

   // Breaker state. It changes only as a result is loaded, so it doubles as
   // the result register for mode and totals.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.mode            <= MODE_CLOSED;
         ctrl_ff.failure_run     <= 16'd0;
         ctrl_ff.probe_requests  <= 8'd0;
         ctrl_ff.probe_successes <= 8'd0;
         change_time_ff          <= '0;
         success_ff              <= '0;
         failure_ff              <= '0;
         reject_ff               <= '0;
      end else if (advance) begin
         ctrl_ff        <= ctrl_in;
         change_time_ff <= change_time_in;
         success_ff     <= success_in;
         failure_ff     <= failure_in;
         reject_ff      <= reject_in;
      end
   end

   // Result valid and the admission flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         admitted_ff <= admitted_in;
      end
   end

   // Result packing; totals are reported in 32 bits.
   assign success_ext = OUT_WIDTH'(success_ff);
   assign failure_ext = OUT_WIDTH'(failure_ff);
   assign reject_ext  = OUT_WIDTH'(reject_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, reject_ext[31:0], failure_ext[31:0], success_ext[31:0],
                        ctrl_ff.mode, admitted_ff};

   // Assertions.
   `CBF_ASSERT_NEXT(a_state_holds_when_idle, clock, reset, !advance,
      $stable(ctrl_ff) && $stable(reject_ff) && $stable(success_ff),
      "breaker state changed without an event")
   `CBF_ASSERT_NEXT(a_reset_op_closes, clock, reset,
      advance && (in_opcode_ff == OP_RESET),
      (ctrl_ff.mode == MODE_CLOSED) && (ctrl_ff.failure_run == 16'd0),
      "reset event did not close the breaker")
   `CBF_ASSERT_IMPLY(a_admit_not_open, clock, reset, rsp_valid_ff && admitted_ff,
      ctrl_ff.mode != MODE_OPEN, "request admitted while the breaker is open")
   `CBF_ASSERT_NEXT(a_event_gives_result, clock, reset, advance, rsp_valid_ff,
      "event advanced without a result")

endmodule

// ===== tb/circuit_breaker_fsm_tb.sv =====
// ----------------------------------------------------------------------------
// Circuit breaker testbench
// Drives timestamped events into the breaker, predicts every result with a
// cycle-free model of the three modes, and checks each result field by field
// under several register settings and idling patterns.
// ----------------------------------------------------------------------------
module circuit_breaker_fsm_tb
   import cbf_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Register index that maps to no register; writes to it must be ignored.
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;
   // Length of the long receiver hold-off, in cycles.
   localparam int LONG_HOLD = 48;
   // Mismatches beyond this many are counted but not printed.
   localparam int MAX_REPORTS = 30;

   // Expected content of one result.
   typedef struct {
      logic        admitted;
      logic [1:0]  mode;
      logic [31:0] success_total;
      logic [31:0] failure_total;
      logic [31:0] reject_total;
   } breaker_outcome_type;

   // Register values and traffic mix of one random phase.
   typedef struct {
      logic [31:0] threshold_word;
      logic [31:0] timeout_word;
      logic [31:0] probe_word;
      int          send_idle;
      int          recv_stall;
      int          w_request;
      int          w_success;
      int          w_failure;
      int          span;
   } phase_plan_type;

   // Tracks the breaker state, predicts each result and checks it on arrival.
   class breaker_scoreboard;
      logic [15:0] trip_threshold;
      logic [31:0] open_timeout;
      logic [7:0]  probe_limit;
      mode_type    mode;
      logic [15:0] failure_run;
      logic [7:0]  probe_requests;
      logic [7:0]  probe_successes;
      logic [31:0] change_time;
      logic [31:0] successes_seen;
      logic [31:0] failures_seen;
      logic [31:0] rejections_seen;
      breaker_outcome_type outcome_q[$];
      int errors;
      int checked;
      int admissions;
      int probes_entered;
      int trips;
      int recoveries;

      function new();
         trip_threshold    = TRIP_THRESHOLD_RESET;
         open_timeout      = OPEN_TIMEOUT_RESET;
         probe_limit       = PROBE_LIMIT_RESET;
         mode              = MODE_CLOSED;
         failure_run       = '0;
         probe_requests    = '0;
         probe_successes   = '0;
         change_time       = '0;
         successes_seen    = '0;
         failures_seen     = '0;
         rejections_seen   = '0;
         errors            = 0;
         checked           = 0;
         admissions        = 0;
         probes_entered    = 0;
         trips             = 0;
         recoveries        = 0;
      endfunction

      function int pending();
         return outcome_q.size();
      endfunction

      // A register write applies to every later event.
      function void write_register(logic [1:0] idx, logic [31:0] value);
         case (idx)
            CSR_TRIP_THRESHOLD: trip_threshold = value[15:0];
            CSR_OPEN_TIMEOUT:   open_timeout   = value;
            CSR_PROBE_LIMIT:    probe_limit    = value[7:0];
            default: ;
         endcase
      endfunction

      // Advances the predicted state by one accepted event and queues its result.
      function void note_event(opcode_type op, logic [31:0] now);
         breaker_outcome_type want;
         logic [31:0] elapsed;
         logic admit;
         admit = 1'b0;
         elapsed = now - change_time;
         case (op)
            OP_REQUEST: begin
               if (mode == MODE_CLOSED) begin
                  admit = 1'b1;
               end else if (mode == MODE_OPEN) begin
                  // The first request after the timeout probes in half-open mode.
                  if (elapsed >= open_timeout) begin
                     mode            = MODE_HALF;
                     change_time     = now;
                     probe_requests  = '0;
                     probe_successes = '0;
                     admit           = 1'b1;
                     probes_entered++;
                  end else begin
                     rejections_seen++;
                  end
               end else if (probe_requests < probe_limit) begin
                  probe_requests++;
                  admit = 1'b1;
               end else begin
                  rejections_seen++;
               end
            end
            OP_SUCCESS: begin
               successes_seen++;
               if (mode == MODE_HALF) begin
                  if (probe_successes != 8'hFF) probe_successes++;
                  if (probe_successes >= probe_limit) begin
                     mode        = MODE_CLOSED;
                     change_time = now;
                     recoveries++;
                  end
               end
               if (mode == MODE_CLOSED) failure_run = '0;
            end
            OP_FAILURE: begin
               failures_seen++;
               if (mode == MODE_CLOSED) begin
                  if (failure_run != 16'hFFFF) failure_run++;
                  if (failure_run >= trip_threshold) begin
                     mode        = MODE_OPEN;
                     change_time = now;
                     trips++;
                  end
               end else if (mode == MODE_HALF) begin
                  mode        = MODE_OPEN;
                  change_time = now;
                  trips++;
               end
            end
            default: begin
               // The reset event clears the mode and run counters only.
               mode            = MODE_CLOSED;
               failure_run     = '0;
               probe_requests  = '0;
               probe_successes = '0;
            end
         endcase
         if (admit) admissions++;
         want.admitted      = admit;
         want.mode          = mode;
         want.success_total = successes_seen;
         want.failure_total = failures_seen;
         want.reject_total  = rejections_seen;
         outcome_q.push_back(want);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: result %0d %s mismatch, expected %0h, actual %0h",
                        $time, checked, name, want, got);
         end
      endfunction

      // Compares one accepted result with the oldest prediction.
      function void check_result(logic [103:0] word);
         breaker_outcome_type want;
         if (outcome_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: unexpected result, expected none, actual %0h", $time, word);
            return;
         end
         want = outcome_q.pop_front();
         compare_field("admitted", 32'(want.admitted), 32'(word[0]));
         compare_field("mode", 32'(want.mode), 32'(word[2:1]));
         compare_field("success_total", want.success_total, word[34:3]);
         compare_field("failure_total", want.failure_total, word[66:35]);
         compare_field("reject_total", want.reject_total, word[98:67]);
         compare_field("padding", 32'd0, 32'(word[103:99]));
         checked++;
      endfunction
   endclass

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  req_tdata  = '0;
   logic [1:0]   req_tuser  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic         csr_valid  = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index  = '0;
   logic [31:0]  csr_wdata  = '0;

   breaker_scoreboard breaker = new();
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          hold_requests  = 0;
   int          hold_served    = 0;
   int          hold_left      = 0;
   int          events_sent    = 0;
   int          settings_used  = 1;
   logic [31:0] last_time      = '0;

   circuit_breaker_fsm dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 4 ns clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Result side: check accepted results, stall at random or for a long hold.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) breaker.check_result(rsp_tdata);
         if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD;
            rsp_tready  <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Offers one event, with random idle cycles first, and waits for acceptance.
   task automatic offer_event(opcode_type op, logic [31:0] t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= t;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      breaker.note_event(op, t);
      last_time = t;
      events_sent++;
   endtask

   // Stops offering and waits until every predicted result has arrived.
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (breaker.pending() != 0) @(posedge clock);
   endtask

   // Writes one register; the caller lowers csr_valid after the last write.
   task automatic write_register(logic [1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      breaker.write_register(idx, value);
   endtask

   function automatic phase_plan_type make_plan(logic [31:0] thr, logic [31:0] tmo,
                                                logic [31:0] prb, int idle, int stall,
                                                int w_req, int w_suc, int w_fail,
                                                int span);
      phase_plan_type plan;
      plan.threshold_word = thr;
      plan.timeout_word   = tmo;
      plan.probe_word     = prb;
      plan.send_idle      = idle;
      plan.recv_stall     = stall;
      plan.w_request      = w_req;
      plan.w_success      = w_suc;
      plan.w_failure      = w_fail;
      plan.span           = span;
      return plan;
   endfunction

   // One random phase: program the registers, then send a mix of events.
   task automatic run_phase(phase_plan_type plan, int count, int pause_at, int hold_at);
      int pick;
      int roll;
      opcode_type op;
      logic [31:0] t;
      write_register(CSR_TRIP_THRESHOLD, plan.threshold_word);
      write_register(CSR_OPEN_TIMEOUT, plan.timeout_word);
      write_register(CSR_PROBE_LIMIT, plan.probe_word);
      csr_valid <= 1'b0;
      send_idle_pct  = plan.send_idle;
      recv_stall_pct = plan.recv_stall;
      settings_used++;
      t = last_time;
      for (int n = 0; n < count; n++) begin
         if (n == pause_at) wait_drain();
         if (n == hold_at) hold_requests <= hold_requests + 1;
         pick = $urandom_range(99);
         if (pick < plan.w_request) op = OP_REQUEST;
         else if (pick < plan.w_request + plan.w_success) op = OP_SUCCESS;
         else if (pick < plan.w_request + plan.w_success + plan.w_failure) op = OP_FAILURE;
         else op = OP_RESET;
         // Mostly forward time, with jumps and a step back to hit the wrap.
         roll = $urandom_range(99);
         if (roll < 8) t = $urandom();
         else if (roll < 20) t = t - 32'd1;
         else t = t + 32'($urandom_range(plan.span));
         offer_event(op, t);
      end
      wait_drain();
   endtask

   // Main sequence: reset, directed events, then random phases.
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Closed mode admits and counts; five failures trip at the default.
      offer_event(OP_REQUEST, 32'd0);
      offer_event(OP_SUCCESS, 32'd1);
      for (int i = 0; i < 5; i++) offer_event(OP_FAILURE, 32'd10 + 32'(i));
      // Open mode rejects; success and failure only move the totals.
      offer_event(OP_REQUEST, 32'd100);
      offer_event(OP_SUCCESS, 32'd101);
      offer_event(OP_FAILURE, 32'd102);
      // Timeout reached: probe, then use up the probe allowance.
      offer_event(OP_REQUEST, 32'd30014);
      for (int i = 0; i < 3; i++) offer_event(OP_REQUEST, 32'd30015 + 32'(i));
      offer_event(OP_REQUEST, 32'd30018);
      for (int i = 0; i < 3; i++) offer_event(OP_SUCCESS, 32'd30020 + 32'(i));
      offer_event(OP_RESET, 32'd30100);
      // Trip just before the time counter wraps, then probe across the wrap.
      for (int i = 0; i < 5; i++) offer_event(OP_FAILURE, 32'hFFFF_FFF0);
      offer_event(OP_REQUEST, 32'hFFFF_FFFF);
      offer_event(OP_REQUEST, 32'd29983);
      offer_event(OP_REQUEST, 32'd29984);
      // A failure in half-open mode reopens; the reset event closes.
      offer_event(OP_FAILURE, 32'd29985);
      offer_event(OP_RESET, 32'd29990);
      wait_drain();

      // A write to the unmapped index must change nothing.
      write_register(CSR_UNMAPPED, $urandom());

      // Minimal threshold and probes, zero timeout, no idling.
      run_phase(make_plan(32'd1, 32'd0, 32'd1, 0, 0, 40, 25, 30, 3), 188, -1, -1);
      // Sender idling, with one pause until all results are in.
      run_phase(make_plan(32'd3, 32'd40, 32'd3, 68, 0, 35, 30, 30, 30), 188, 95, -1);
      // Zero threshold and zero probe limit, receiver stalling.
      run_phase(make_plan(32'd0, 32'd10, 32'd0, 0, 68, 35, 30, 30, 8), 188, -1, -1);
      // Longest timeout and probe limit; upper write bits must be dropped.
      run_phase(make_plan(32'hFFFF_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16, 16,
                          35, 25, 35, 1000), 188, -1, -1);
      // Largest threshold with mostly failures, building a long failure run.
      run_phase(make_plan(32'h0000_FFFF, 32'd30000, 32'd1, 0, 0, 10, 5, 85, 500),
                188, -1, -1);
      // Lowered threshold below the run; a long receiver hold fills the block.
      run_phase(make_plan(32'd2, 32'd1, 32'd2, 16, 16, 35, 30, 30, 2), 188, -1, 60);

      repeat (8) @(posedge clock);
      $display("Checked %0d results from %0d events over %0d register settings.",
               breaker.checked, events_sent, settings_used);
      $display("Admitted %0d, rejected %0d, tripped open %0d, probed %0d, recovered %0d.",
               breaker.admissions, breaker.rejections_seen, breaker.trips,
               breaker.probes_entered, breaker.recoveries);
      if (breaker.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2_000_000;
      $display("Timeout with %0d results outstanding.", breaker.pending());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
